[design/pcgb_pkg.sv]
// ----------------------------------------------------------------------------
// pcgb_pkg : shared types and constants of the PCG32 bounded generator
// Command codes, sequencer states, LCG constants and the XSH-RR output mix.
// ----------------------------------------------------------------------------
package pcgb_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STATE_W    = 64;
  localparam int unsigned STREAM_W   = 63;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned CMD_W      = 2;

  localparam logic [STATE_W-1:0] LCG_MULT    = 64'h5851_F42D_4C95_7F2D;
  // State after seeding from zero seed and stream zero.
  localparam logic [STATE_W-1:0] RESET_STATE = 64'h5851_F42D_4C95_7F2E;
  localparam logic [STATE_W-1:0] RESET_INC   = 64'd1;

  localparam int unsigned XS_SHIFT  = 18;
  localparam int unsigned MIX_SHIFT = 27;
  localparam int unsigned ROT_SHIFT = 59;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESEED  = 2'd0,
    CMD_RAW     = 2'd1,
    CMD_BOUNDED = 2'd2,
    CMD_RANGE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_LIM,
    S_DIV,
    S_M0,
    S_M1,
    S_M2,
    S_ADD,
    S_BMUL,
    S_CHK,
    S_OUT
  } seq_state_t;

  // XSH-RR: xorshift high, then rotate right by the top five bits.
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
    logic [STATE_W-1:0]  xs;
    logic [WORD_W-1:0]   mixed;
    logic [4:0]          rot;
    logic [2*WORD_W-1:0] dbl;
    xs    = (old >> XS_SHIFT) ^ old;
    mixed = xs[MIX_SHIFT +: WORD_W];
    rot   = old[ROT_SHIFT +: 5];
    dbl   = {mixed, mixed} >> rot;
    return dbl[WORD_W-1:0];
  endfunction

endpackage

[design/pcg32_bounded_random_generator.sv]
// ----------------------------------------------------------------------------
// pcg32_bounded_random_generator : PCG32 (XSH-RR) with unbiased bounded draws
// One shared 32x32 multiplier, stepped by a small sequencer, advances the
// 64-bit LCG and forms the bounded product; a bit-serial unit finds the
// rejection threshold.
// ----------------------------------------------------------------------------
// Raw draw: takes its word and steps the LCG (S_M0 to S_ADD), then S_OUT.
// Reseed: S_SEED, then the same LCG step, with no result. Bounded and range
// draws: 32-step remainder, then LCG step, product and compare, redone for
// every rejected word. Bound of zero or one, reversed or full range: no draw.
// Throughput: one item at a time; s_tready is high only while idle.
// Reset (rst, synchronous): generator state as if reseeded from zero seed and
// stream zero, increment one, result register empty.
// ----------------------------------------------------------------------------
module pcg32_bounded_random_generator import pcgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // bound[31:0], range_low[63:32], range_high[95:64]
  input  logic [CMD_W-1:0]      s_tuser,   // cmd[1:0]
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [WORD_W-1:0]     m_tdata    // value[31:0]
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [STATE_W-1:0]  seed_value;
  logic [STREAM_W-1:0] stream_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value    <= '0;
      stream_select <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:   seed_value    <= cfg_data;
        CFG_STREAM: stream_select <= cfg_data[STREAM_W-1:0];
        default:    ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] in_bound;
  logic [WORD_W-1:0] in_low;
  logic [WORD_W-1:0] in_high;
  cmd_t              in_cmd;
  logic              in_lt;
  logic [WORD_W-1:0] in_width;

  assign in_bound = s_tdata[WORD_W-1:0];
  assign in_low   = s_tdata[2*WORD_W-1:WORD_W];
  assign in_high  = s_tdata[3*WORD_W-1:2*WORD_W];
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_lt    = $signed(in_low) < $signed(in_high);
  assign in_width = in_high - in_low + WORD_W'(1);

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  seq_state_t          fsm;
  seq_state_t          fsm_next;
  cmd_t                cmd;
  logic [WORD_W-1:0]   base;     // added to a bounded draw (range low, else zero)
  logic [WORD_W-1:0]   limit;    // bound of the draw; zero or one means no draw
  logic [WORD_W-1:0]   thresh;   // rejection threshold
  logic [WORD_W-1:0]   word;     // output word of the latest step
  logic [STATE_W-1:0]  acc;      // partial LCG product
  logic [STATE_W-1:0]  prod;     // registered multiplier output
  logic [STATE_W-1:0]  gen_state;
  logic [STATE_W-1:0]  stream_increment;
  logic [WORD_W-1:0]   result;

  logic                accept;
  logic                out_free;
  logic                limit_trivial;
  logic                draw_ok;
  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_rem;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [STATE_W-1:0]  mul_p;

  assign accept        = s_tvalid && s_tready;
  assign out_free      = !m_tvalid || m_tready;
  assign limit_trivial = (limit[WORD_W-1:1] == '0);
  assign draw_ok       = (prod[WORD_W-1:0] >= thresh);

  // Next state
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_cmd)
            CMD_RESEED: fsm_next = S_SEED;
            CMD_RAW:    fsm_next = S_M0;
            default:    fsm_next = S_LIM;
          endcase
        end
      end
      S_SEED:  fsm_next = S_M0;
      S_LIM:   fsm_next = limit_trivial ? S_OUT : S_DIV;
      S_DIV:   fsm_next = div_done ? S_M0 : S_DIV;
      S_M0:    fsm_next = S_M1;
      S_M1:    fsm_next = S_M2;
      S_M2:    fsm_next = S_ADD;
      S_ADD: begin
        unique case (cmd)
          CMD_RESEED: fsm_next = S_IDLE;
          CMD_RAW:    fsm_next = S_OUT;
          default:    fsm_next = S_BMUL;
        endcase
      end
      S_BMUL:  fsm_next = S_CHK;
      S_CHK:   fsm_next = draw_ok ? S_OUT : S_M0;
      S_OUT:   fsm_next = out_free ? S_IDLE : S_OUT;
      default: fsm_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, divider kick and multiplier operands.
  // The LCG step keeps only the low 64 bits of state * multiplier, so the
  // high-by-high partial product is never needed.
  always_comb begin
    s_tready  = (fsm == S_IDLE);
    div_start = (fsm == S_LIM) && !limit_trivial;
    unique case (fsm)
      S_M0: begin
        mul_a = gen_state[WORD_W-1:0];
        mul_b = LCG_MULT[WORD_W-1:0];
      end
      S_M1: begin
        mul_a = gen_state[WORD_W-1:0];
        mul_b = LCG_MULT[STATE_W-1:WORD_W];
      end
      S_M2: begin
        mul_a = gen_state[STATE_W-1:WORD_W];
        mul_b = LCG_MULT[WORD_W-1:0];
      end
      default: begin
        mul_a = word;
        mul_b = limit;
      end
    endcase
  end

  // The one shared multiplier, registered every cycle.
  assign mul_p = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  // Generator state: reset value is the reseed of the reset configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state        <= RESET_STATE;
      stream_increment <= RESET_INC;
    end else begin
      unique case (fsm)
        // Seeding from zero: the first step leaves the increment, then add seed.
        S_SEED: begin
          stream_increment <= {stream_select, 1'b1};
          gen_state        <= {stream_select, 1'b1} + seed_value;
        end
        S_ADD: begin
          gen_state <= acc + {prod[WORD_W-1:0], {WORD_W{1'b0}}} + stream_increment;
        end
        default: ;
      endcase
    end
  end

  // Item payload and partial products
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= in_cmd;
      base  <= (in_cmd == CMD_RANGE) ? in_low : '0;
      // A reversed range draws nothing: hand it a limit of zero.
      limit <= (in_cmd == CMD_RANGE) ? (in_lt ? in_width : '0) : in_bound;
    end
    if (fsm == S_DIV && div_done) begin
      thresh <= div_rem;
    end
    unique case (fsm)
      S_LIM: begin
        result <= base;
      end
      S_M0: begin
        word <= xsh_rr(gen_state);
      end
      S_M1: begin
        acc <= prod;
      end
      S_M2: begin
        acc[STATE_W-1:WORD_W] <= acc[STATE_W-1:WORD_W] + prod[WORD_W-1:0];
      end
      S_ADD: begin
        result <= word;
      end
      S_CHK: begin
        result <= base + prod[STATE_W-1:WORD_W];
      end
      default: ;
    endcase
  end

  // Output register: holds a finished item while the next one is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fsm == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == S_OUT && out_free) begin
      m_tdata <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Threshold unit: (2^32 - limit) mod limit
  // --------------------------------------------------------------------------
  pcgb_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (WORD_W'(0) - limit),
    .divisor  (limit),
    .done     (div_done),
    .rem      (div_rem)
  );

endmodule

[design/pcgb_rem.sv]
// ----------------------------------------------------------------------------
// pcgb_rem : iterative 32-bit remainder
// Restoring division, one quotient bit a cycle; pulses done with the remainder.
// ----------------------------------------------------------------------------
module pcgb_rem import pcgb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] rem
);

  localparam int unsigned STEPS = WORD_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem, quo[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload: load on start, shift one dividend bit in per cycle while busy.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end

endmodule

[design/pcgb_checker.sv]
// ----------------------------------------------------------------------------
// pcgb_checker : port-level checks for the PCG32 bounded generator
// Watches the stream handshakes and the reset behaviour of the top level.
// ----------------------------------------------------------------------------
module pcgb_checker import pcgb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [WORD_W-1:0] m_tdata
);

  // After reset the block is idle and holds no result.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("not idle and empty after reset");

  // Every item keeps the block busy at least for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready again right after accepting an item");

  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind pcg32_bounded_random_generator pcgb_checker u_pcgb_checker (.*);
